// ----- hw/rtl/maze_dfs_backtracker_assert.svh -----
// Assertion macros shared by the maze carver RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef MAZE_DFS_BACKTRACKER_ASSERT_SVH
`define MAZE_DFS_BACKTRACKER_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define MDB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define MDB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mdb_pkg.sv -----
// Shared constants, codes and types for the maze carver.
// No dependencies.
package mdb_pkg;

  // Field widths fixed by the interface
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int RND_W      = 31;
  localparam int ST_W       = 3;

  // Default sizing
  localparam int MAX_SIDE_DEF    = 64;
  localparam int STACK_DEPTH_DEF = 1024;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_HEIGHT = 1'b1;

  // Input operations
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_STARTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_CARVED   = 3'd1;
  localparam logic [ST_W-1:0] ST_BACK     = 3'd2;
  localparam logic [ST_W-1:0] ST_FINISHED = 3'd3;
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd4;

  // Walk phase
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WALK = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // Directions, in candidate listing order
  localparam int NUM_DIRS = 4;
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_S = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Chosen direction
  typedef struct packed {
    logic       has;
    logic [1:0] dir;
  } pick_t;

endpackage

// ----- hw/rtl/mdb_pick.sv -----
// Neighbor choice: random value modulo candidate count, then the k-th candidate.
// Depends on mdb_pkg.
module mdb_pick (
  input  logic [mdb_pkg::NUM_DIRS-1:0] cand,
  input  logic [mdb_pkg::RND_W-1:0]    rnd,
  output mdb_pkg::pick_t               pick
);
  import mdb_pkg::*;

  logic [2:0] n;
  logic [1:0] k;
  logic [2:0] seen;

  // Value mod 3: nibble sum (16 is 1 mod 3), then digit folds
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [31:0] w;
    logic [6:0]  s1;
    logic [4:0]  s2;
    logic [2:0]  s3;
    logic [2:0]  r;
    w  = 32'(v);
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 7'(w[4*i +: 4]);
    end
    s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
    s3 = 3'(s2[4]) + 3'(s2[3:2]) + 3'(s2[1:0]);
    if (s3 >= 3'd6) begin
      r = s3 - 3'd6;
    end else if (s3 >= 3'd3) begin
      r = s3 - 3'd3;
    end else begin
      r = s3;
    end
    return r[1:0];
  endfunction

  always_comb begin
    n = 3'($countones(cand));
    // index among the candidates
    unique case (n)
      3'd2:    k = {1'b0, rnd[0]};
      3'd3:    k = mod3(rnd);
      3'd4:    k = rnd[1:0];
      default: k = 2'd0;
    endcase
    pick.has = (n != 3'd0);
    pick.dir = DIR_N;
    seen     = '0;
    // walk the candidates in N, S, E, W order
    for (int i = 0; i < NUM_DIRS; i++) begin
      if (cand[i]) begin
        if (seen == {1'b0, k}) pick.dir = 2'(i);
        seen = seen + 3'd1;
      end
    end
  end

endmodule

// ----- hw/rtl/maze_dfs_backtracker.sv -----
// Maze carver top level: grid and stack memories, step sequencer, output register.
// Depends on mdb_pkg, mdb_pick and maze_dfs_backtracker_assert.svh.
//
// Usage: write maze_width (index 0) and maze_height (index 1) on the cfg channel
// (always ready) while idle; the sizes are latched by the next start beat.
// Each in beat gives one out beat. op=start clears the grid row by row, opens
// cell (1,1) and pushes it; op=step examines the stack top and carves, pops or
// reports finished.
// Sequencer path from in accept back to idle (S_OUT waits for the output register):
//   start: S_CLEAR (one grid row cleared per cycle), S_OUT;
//   carve: S_TOP, S_RDN, S_RDS, S_RDC, S_PICK, S_WRW, S_WRC, S_OUT;
//   backtrack: S_TOP to S_PICK, S_OUT; not started / finished: S_OUT. A carve does
// one stack read, three row reads (north, south, own row) and two bit writes, one per state.
// in_ready is high only while the sequencer is idle. Results sit in an output
// register, so the next item is taken while a result waits; if out_ready stays
// low, a finished item holds in its last step until the register frees up.
// Reset: no maze, stack empty, configured sizes 63 (latched sides 3), out_valid low. Steps before the first
// start report not started. The grid needs no clear at reset: start clears it.
module maze_dfs_backtracker #(
  parameter  int MAX_SIDE    = mdb_pkg::MAX_SIDE_DEF,
  parameter  int STACK_DEPTH = mdb_pkg::STACK_DEPTH_DEF,
  localparam int CW          = $clog2(MAX_SIDE),
  localparam int LW          = $clog2(STACK_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mdb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mdb_pkg::CFG_W-1:0]     cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [mdb_pkg::RND_W-1:0]     in_random_value,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mdb_pkg::ST_W-1:0]      out_status,
  output logic [CW-1:0]                 out_cell_x,
  output logic [CW-1:0]                 out_cell_y,
  output logic [CW-1:0]                 out_wall_x,
  output logic [CW-1:0]                 out_wall_y,
  output logic [LW-1:0]                 out_stack_level
);
  import mdb_pkg::*;
  `include "maze_dfs_backtracker_assert.svh"

  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int DW  = CW + 2;

  localparam logic [CW-1:0]        CLR_LAST = CW'(MAX_SIDE - 1);
  localparam logic signed [DW-1:0] TWO_S    = DW'(2);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_TOP   = 4'd2;
  localparam logic [3:0] S_RDN   = 4'd3;
  localparam logic [3:0] S_RDS   = 4'd4;
  localparam logic [3:0] S_RDC   = 4'd5;
  localparam logic [3:0] S_PICK  = 4'd6;
  localparam logic [3:0] S_WRW   = 4'd7;
  localparam logic [3:0] S_WRC   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [CW-1:0]   cx;
    logic [CW-1:0]   cy;
    logic [CW-1:0]   wx;
    logic [CW-1:0]   wy;
    logic [LW-1:0]   level;
  } res_t;

  // Control registers
  logic [3:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic [CFG_W-1:0] cfg_w_r, cfg_h_r;
  logic [SW-1:0]    side_w_r, side_w_nxt;
  logic [SW-1:0]    side_h_r, side_h_nxt;
  logic             out_valid_r;
  logic             out_load;

  // Working registers
  logic [RND_W-1:0] rnd_r, rnd_nxt;
  logic [CW-1:0]    clr_row_r, clr_row_nxt;
  logic [CW-1:0]    cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CW-1:0]    nx_r, nx_nxt, ny_r, ny_nxt;
  logic [CW-1:0]    wx_r, wx_nxt, wy_r, wy_nxt;
  logic             open_n_r, open_n_nxt, open_s_r, open_s_nxt;
  res_t             res_r, res_nxt;
  res_t             out_r;

  // Memory ports
  logic [2*CW-1:0]     stk_mem [STACK_DEPTH];
  logic [2*CW-1:0]     stk_q;
  logic                stk_rd_en, stk_wr_en;
  logic [SAW-1:0]      stk_rd_addr, stk_wr_addr;
  logic [2*CW-1:0]     stk_wr_data;
  logic [LW-1:0]       cnt_m1;

  logic [MAX_SIDE-1:0] grid_mem [MAX_SIDE];
  logic [MAX_SIDE-1:0] grid_q;
  logic [MAX_SIDE-1:0] grid_clr_val;
  logic                grid_rd_en, grid_clr_en, grid_set_en;
  logic [CW-1:0]       grid_rd_row, grid_wr_row, grid_wr_col;

  // Candidate evaluation
  logic signed [DW-1:0]  cx_s, cy_s;
  logic [CW-1:0]         col_e, col_w;
  logic [NUM_DIRS-1:0]   cand;
  pick_t                 pick;

  function automatic logic [SW-1:0] clamp_side(input logic [CFG_W-1:0] v);
    logic [SW-1:0] r;
    if (v < CFG_W'(3)) begin
      r = SW'(3);
    end else if (int'(v) > MAX_SIDE) begin
      r = SW'(MAX_SIDE);
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  // strictly inside the border walls
  function automatic logic inside_span(input logic signed [DW-1:0] p,
                                       input logic [SW-1:0] side);
    logic signed [DW-1:0] lim;
    lim = $signed({{(DW-SW){1'b0}}, side}) - $signed(DW'(1));
    return (p > $signed(DW'(0))) && (p < lim);
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cnt_m1    = cnt_r - LW'(1);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= CFG_W'(63);
      cfg_h_r <= CFG_W'(63);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAZE_WIDTH:  cfg_w_r <= cfg_data;
        CFG_MAZE_HEIGHT: cfg_h_r <= cfg_data;
      endcase
    end
  end

  // Candidate cells two away from the current top
  assign cx_s  = $signed({2'b00, cx_r});
  assign cy_s  = $signed({2'b00, cy_r});
  assign col_e = cx_r + CW'(2);
  assign col_w = cx_r - CW'(2);

  always_comb begin
    cand[DIR_N] = inside_span(cx_s, side_w_r) && inside_span(cy_s - TWO_S, side_h_r)
                  && !open_n_r;
    cand[DIR_S] = inside_span(cx_s, side_w_r) && inside_span(cy_s + TWO_S, side_h_r)
                  && !open_s_r;
    cand[DIR_E] = inside_span(cx_s + TWO_S, side_w_r) && inside_span(cy_s, side_h_r)
                  && !grid_q[col_e];
    cand[DIR_W] = inside_span(cx_s - TWO_S, side_w_r) && inside_span(cy_s, side_h_r)
                  && !grid_q[col_w];
  end

  mdb_pick u_pick (
    .cand (cand),
    .rnd  (rnd_r),
    .pick (pick)
  );

  // Clear pass value: row 1 comes back with cell (1,1) open
  assign grid_clr_val = (clr_row_r == CW'(1)) ? {{(MAX_SIDE-2){1'b0}}, 2'b10} : '0;

  // Step sequencer
  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    side_w_nxt  = side_w_r;
    side_h_nxt  = side_h_r;
    rnd_nxt     = rnd_r;
    clr_row_nxt = clr_row_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    nx_nxt      = nx_r;
    ny_nxt      = ny_r;
    wx_nxt      = wx_r;
    wy_nxt      = wy_r;
    open_n_nxt  = open_n_r;
    open_s_nxt  = open_s_r;
    res_nxt     = res_r;
    out_load    = 1'b0;
    stk_rd_en   = 1'b0;
    stk_rd_addr = cnt_m1[SAW-1:0];
    stk_wr_en   = 1'b0;
    stk_wr_addr = cnt_r[SAW-1:0];
    stk_wr_data = {ny_r, nx_r};
    grid_rd_en  = 1'b0;
    grid_rd_row = cy_r;
    grid_clr_en = 1'b0;
    grid_set_en = 1'b0;
    grid_wr_row = clr_row_r;
    grid_wr_col = nx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rnd_nxt = in_random_value;
          if (in_op == OP_START) begin
            side_w_nxt  = clamp_side(cfg_w_r);
            side_h_nxt  = clamp_side(cfg_h_r);
            clr_row_nxt = '0;
            state_nxt   = S_CLEAR;
          end else if (phase_r == PH_IDLE) begin
            res_nxt   = '{ST_IDLE, '0, '0, '0, '0, cnt_r};
            state_nxt = S_OUT;
          end else if (phase_r == PH_DONE || cnt_r == '0) begin
            phase_nxt = PH_DONE;
            cnt_nxt   = '0;
            res_nxt   = '{ST_FINISHED, CW'(side_w_r - SW'(2)), CW'(side_h_r - SW'(2)),
                         '0, '0, '0};
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_TOP;
          end
        end
      end

      // one grid row per cycle
      S_CLEAR: begin
        grid_clr_en = 1'b1;
        grid_wr_row = clr_row_r;
        clr_row_nxt = clr_row_r + CW'(1);
        if (clr_row_r == CLR_LAST) begin
          stk_wr_en   = 1'b1;
          stk_wr_addr = '0;
          stk_wr_data = {CW'(1), CW'(1)};
          cnt_nxt     = LW'(1);
          phase_nxt   = PH_WALK;
          res_nxt     = '{ST_STARTED, CW'(1), CW'(1), '0, '0, LW'(1)};
          state_nxt   = S_OUT;
        end
      end

      S_TOP: begin
        stk_rd_en = 1'b1;
        state_nxt = S_RDN;
      end

      // top entry arrives; fetch the north row
      S_RDN: begin
        cx_nxt      = stk_q[CW-1:0];
        cy_nxt      = stk_q[2*CW-1:CW];
        grid_rd_en  = 1'b1;
        grid_rd_row = stk_q[2*CW-1:CW] - CW'(2);
        state_nxt   = S_RDS;
      end

      S_RDS: begin
        open_n_nxt  = grid_q[cx_r];
        grid_rd_en  = 1'b1;
        grid_rd_row = cy_r + CW'(2);
        state_nxt   = S_RDC;
      end

      S_RDC: begin
        open_s_nxt  = grid_q[cx_r];
        grid_rd_en  = 1'b1;
        grid_rd_row = cy_r;
        state_nxt   = S_PICK;
      end

      // own row in grid_q: decide carve or pop
      S_PICK: begin
        if (pick.has && cnt_r < LW'(STACK_DEPTH)) begin
          nx_nxt = cx_r;
          ny_nxt = cy_r;
          wx_nxt = cx_r;
          wy_nxt = cy_r;
          unique case (pick.dir)
            DIR_N: begin
              ny_nxt = cy_r - CW'(2);
              wy_nxt = cy_r - CW'(1);
            end
            DIR_S: begin
              ny_nxt = cy_r + CW'(2);
              wy_nxt = cy_r + CW'(1);
            end
            DIR_E: begin
              nx_nxt = cx_r + CW'(2);
              wx_nxt = cx_r + CW'(1);
            end
            DIR_W: begin
              nx_nxt = cx_r - CW'(2);
              wx_nxt = cx_r - CW'(1);
            end
          endcase
          state_nxt = S_WRW;
        end else begin
          cnt_nxt   = cnt_m1;
          res_nxt   = '{ST_BACK, cx_r, cy_r, '0, '0, cnt_m1};
          state_nxt = S_OUT;
        end
      end

      // open the wall, push the new cell
      S_WRW: begin
        grid_set_en = 1'b1;
        grid_wr_row = wy_r;
        grid_wr_col = wx_r;
        stk_wr_en   = 1'b1;
        stk_wr_addr = cnt_r[SAW-1:0];
        stk_wr_data = {ny_r, nx_r};
        state_nxt   = S_WRC;
      end

      // open the new cell
      S_WRC: begin
        grid_set_en = 1'b1;
        grid_wr_row = ny_r;
        grid_wr_col = nx_r;
        cnt_nxt     = cnt_r + LW'(1);
        res_nxt     = '{ST_CARVED, nx_r, ny_r, wx_r, wy_r, cnt_r + LW'(1)};
        state_nxt   = S_OUT;
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      side_w_r    <= SW'(3);
      side_h_r    <= SW'(3);
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      side_w_r <= side_w_nxt;
      side_h_r <= side_h_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rnd_r     <= rnd_nxt;
    clr_row_r <= clr_row_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    nx_r      <= nx_nxt;
    ny_r      <= ny_nxt;
    wx_r      <= wx_nxt;
    wy_r      <= wy_nxt;
    open_n_r  <= open_n_nxt;
    open_s_r  <= open_s_nxt;
    res_r     <= res_nxt;
    if (out_load) out_r <= res_r;
  end

  // Position stack: one write, one registered read
  always_ff @(posedge clk) begin
    if (stk_wr_en) stk_mem[stk_wr_addr] <= stk_wr_data;
    if (stk_rd_en) stk_q <= stk_mem[stk_rd_addr];
  end

  // Grid: row-wide clear or single-bit set, one registered row read
  always_ff @(posedge clk) begin
    if (grid_clr_en) begin
      grid_mem[grid_wr_row] <= grid_clr_val;
    end else if (grid_set_en) begin
      grid_mem[grid_wr_row][grid_wr_col] <= 1'b1;
    end
    if (grid_rd_en) grid_q <= grid_mem[grid_rd_row];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_cell_x      = out_r.cx;
  assign out_cell_y      = out_r.cy;
  assign out_wall_x      = out_r.wx;
  assign out_wall_y      = out_r.wy;
  assign out_stack_level = out_r.level;

  // Checks
  `MDB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= LW'(STACK_DEPTH), "stack count above depth")
  `MDB_ASSERT_IMP(a_odd_cell, state_r == S_WRW, nx_r[0] && ny_r[0] && (wx_r[0] != wy_r[0]), "carve off the cell lattice")
  `MDB_ASSERT_NXT(a_push, state_r == S_WRC, cnt_r == $past(cnt_r) + LW'(1), "push did not bump count")
  `MDB_ASSERT_NXT(a_clear_end, state_r == S_CLEAR && clr_row_r == CLR_LAST, state_r == S_OUT && cnt_r == LW'(1) && phase_r == PH_WALK, "clear pass did not seed walk")

endmodule
